/* rtl/pis_pkg.sv */
// Shared types, widths and register codes for the PID controller with integral separation.
`timescale 1ns / 1ps

package pis_pkg;

   // Field and register widths
   localparam int ValueWidth     = 16;
   localparam int GainWidth      = 16;
   localparam int LimitWidth     = 15;
   localparam int ClampWidth     = 23;
   localparam int ThrottleWidth  = 11;
   localparam int ErrorWidth     = 17;
   localparam int DiffWidth      = 18;
   localparam int IntegralWidth  = 24;
   localparam int AccWidth       = 25;
   localparam int KpTermWidth    = 34;
   localparam int KiTermWidth    = 41;
   localparam int KdTermWidth    = 35;
   localparam int SumWidth       = 43;
   localparam int ShiftWidth     = SumWidth - 8;
   localparam int DriveWidth     = 32;
   localparam int ReqDataWidth   = 48;
   localparam int RspDataWidth   = 32;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 23;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_KP_GAIN            = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KI_GAIN            = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KD_GAIN            = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SEPARATION_LIMIT   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_INTEGRAL_CLAMP     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_THROTTLE_THRESHOLD = 3'd5;

   // Register reset values
   localparam logic [LimitWidth-1:0]    SEPARATION_LIMIT_RESET   = 15'd4000;
   localparam logic [ClampWidth-1:0]    INTEGRAL_CLAMP_RESET     = 23'd32000;
   localparam logic [ThrottleWidth-1:0] THROTTLE_THRESHOLD_RESET = 11'd180;

   typedef struct packed {
      logic [GainWidth-1:0]     kp_gain;
      logic [GainWidth-1:0]     ki_gain;
      logic [GainWidth-1:0]     kd_gain;
      logic [LimitWidth-1:0]    separation_limit;
      logic [ClampWidth-1:0]    integral_clamp;
      logic [ThrottleWidth-1:0] throttle_threshold;
   } cfg_type;

   typedef struct packed {
      logic [ThrottleWidth-1:0]     throttle;
      logic                         armed;
      logic signed [ValueWidth-1:0] measured_value;
      logic signed [ValueWidth-1:0] target_value;
   } req_fields_type;

   typedef struct packed {
      logic signed [KpTermWidth-1:0] kp_term;
      logic signed [KiTermWidth-1:0] ki_term;
      logic signed [KdTermWidth-1:0] kd_term;
   } prod_type;

endpackage

/* rtl/pid_integral_separation.sv */
// Top level of the positional PID controller with integral separation.
// The result passes the input, product and result registers, in that order.
// Throughput: one transaction per cycle while the result stream is not stalled; stages advance on their own ready.
// The gain multipliers and the state update sit between the input and product registers.
// Reset is synchronous, active high: clears pipeline valids, controller state and registers
// (separation limit 4000, integral clamp 32000, throttle threshold 180, gains zero).
`timescale 1ns / 1ps

module pid_integral_separation import pis_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Input stream; tdata: target_value[15:0], measured_value[31:16], armed[32],
   // throttle[43:33], zero pad[47:44]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,
   // Result stream; tdata: drive_value[31:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,
   // Configuration write port
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type  cfg;
   logic     prod_valid;
   logic     prod_ready;
   prod_type prod;

   pis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pis_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   pis_output u_output (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/pis_csr.sv */
// Configuration register file for the PID controller.
`timescale 1ns / 1ps

module pis_csr import pis_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KP_GAIN:            cfg_in.kp_gain = csr_wdata[GainWidth-1:0];
            CSR_KI_GAIN:            cfg_in.ki_gain = csr_wdata[GainWidth-1:0];
            CSR_KD_GAIN:            cfg_in.kd_gain = csr_wdata[GainWidth-1:0];
            CSR_SEPARATION_LIMIT:   cfg_in.separation_limit = csr_wdata[LimitWidth-1:0];
            CSR_INTEGRAL_CLAMP:     cfg_in.integral_clamp = csr_wdata[ClampWidth-1:0];
            CSR_THROTTLE_THRESHOLD: cfg_in.throttle_threshold = csr_wdata[ThrottleWidth-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain            <= '0;
         cfg_ff.ki_gain            <= '0;
         cfg_ff.kd_gain            <= '0;
         cfg_ff.separation_limit   <= SEPARATION_LIMIT_RESET;
         cfg_ff.integral_clamp     <= INTEGRAL_CLAMP_RESET;
         cfg_ff.throttle_threshold <= THROTTLE_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/pis_core.sv */
// Input register, controller state update and gain products of the PID controller.
`timescale 1ns / 1ps

module pis_core import pis_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    prod_valid,
   input  logic                    prod_ready,
   output prod_type                prod
);

   logic                          in_valid_ff;
   req_fields_type                in_data_ff;
   logic signed [ErrorWidth-1:0]    prev_error_ff, prev_error_in;
   logic signed [IntegralWidth-1:0] integral_ff, integral_in;
   logic                          flag_ff, flag_in;
   logic                          prod_valid_ff;
   prod_type                      prod_ff, prod_in;

   logic                          prod_slot_free;
   logic                          step_en;
   logic signed [ErrorWidth-1:0]    error;
   logic signed [DiffWidth-1:0]     difference;
   logic signed [GainWidth:0]       kp_s, ki_s, kd_s;
   logic signed [ValueWidth:0]      measure_x, limit_x;
   logic signed [AccWidth-1:0]      acc, clamp_x;
   logic                          integrate_on;
   logic                          separated;

   // Handshake: the product register frees when its transaction moves on
   assign prod_slot_free = !prod_valid_ff || prod_ready;
   assign step_en        = in_valid_ff && prod_slot_free;
   assign req_tready     = !in_valid_ff || prod_slot_free;

   // Error, difference and the three gain products from the pre-step state
   always_comb begin
      error = $signed({in_data_ff.target_value[ValueWidth-1], in_data_ff.target_value})
            - $signed({in_data_ff.measured_value[ValueWidth-1], in_data_ff.measured_value});
      difference = $signed({error[ErrorWidth-1], error})
                 - $signed({prev_error_ff[ErrorWidth-1], prev_error_ff});
      kp_s = $signed({1'b0, cfg.kp_gain});
      ki_s = $signed({1'b0, cfg.ki_gain});
      kd_s = $signed({1'b0, cfg.kd_gain});
      prod_in.kp_term = kp_s * error;
      prod_in.kd_term = kd_s * difference;
      if (flag_ff) begin
         prod_in.ki_term = ki_s * integral_ff;
      end else begin
         prod_in.ki_term = '0;
      end
   end

   // Integral separation and clamp; the integral clears when not armed or below the throttle threshold
   always_comb begin
      measure_x    = $signed({in_data_ff.measured_value[ValueWidth-1], in_data_ff.measured_value});
      limit_x      = $signed({2'b00, cfg.separation_limit});
      integrate_on = in_data_ff.armed && (in_data_ff.throttle >= cfg.throttle_threshold);
      separated    = (measure_x > limit_x) || (measure_x < -limit_x);
      acc          = $signed({integral_ff[IntegralWidth-1], integral_ff})
                   + $signed({{(AccWidth-ErrorWidth){error[ErrorWidth-1]}}, error});
      clamp_x      = $signed({2'b00, cfg.integral_clamp});
      flag_in      = flag_ff;
      integral_in  = integral_ff;
      if (integrate_on) begin
         if (separated) begin
            flag_in = 1'b0;
         end else begin
            flag_in = 1'b1;
            if (acc > clamp_x) begin
               integral_in = clamp_x[IntegralWidth-1:0];
            end else if (acc < -clamp_x) begin
               integral_in = -clamp_x[IntegralWidth-1:0];
            end else begin
               integral_in = acc[IntegralWidth-1:0];
            end
         end
      end else begin
         integral_in = '0;
      end
      prev_error_in = error;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_fields_type'(req_tdata[$bits(req_fields_type)-1:0]);
      end
   end

   // Controller state advances once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
         flag_ff       <= 1'b0;
      end else if (step_en) begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
         flag_ff       <= flag_in;
      end
   end

   // Product register
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_slot_free) begin
         prod_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

/* rtl/pis_output.sv */
// Product sum, Q.8 rescale, saturation and result register of the PID controller.
`timescale 1ns / 1ps

module pis_output import pis_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    prod_valid,
   output logic                    prod_ready,
   input  prod_type                prod,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic                          rsp_valid_ff;
   logic [DriveWidth-1:0]         drive_ff, drive_in;
   logic signed [SumWidth-1:0]    sum;
   logic signed [ShiftWidth-1:0]  shifted;

   assign prod_ready = !rsp_valid_ff || rsp_tready;

   // Sum the terms, floor-shift by 8 and saturate to 32 bits
   always_comb begin
      sum = $signed({{(SumWidth-KpTermWidth){prod.kp_term[KpTermWidth-1]}}, prod.kp_term})
          + $signed({{(SumWidth-KiTermWidth){prod.ki_term[KiTermWidth-1]}}, prod.ki_term})
          + $signed({{(SumWidth-KdTermWidth){prod.kd_term[KdTermWidth-1]}}, prod.kd_term});
      shifted = sum[SumWidth-1:8];
      if (shifted[ShiftWidth-1:DriveWidth-1] == '0
          || shifted[ShiftWidth-1:DriveWidth-1] == '1) begin
         drive_in = shifted[DriveWidth-1:0];
      end else if (shifted[ShiftWidth-1]) begin
         drive_in = {1'b1, {(DriveWidth-1){1'b0}}};
      end else begin
         drive_in = {1'b0, {(DriveWidth-1){1'b1}}};
      end
   end

   // Result register: hold while the transaction waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         rsp_valid_ff <= prod_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

endmodule

/* rtl/pis_checker.sv */
// Port-level assertions for the PID controller and their bind to the top level.
`timescale 1ns / 1ps

module pis_checker import pis_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   // A stalled result transaction stays and holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // With no result pending every stage can move, so input is taken
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // No result is valid directly after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result appeared right after reset");

endmodule

bind pid_integral_separation pis_checker u_pis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/tb_pid_integral_separation.sv */
// Self-checking testbench for the PID controller with integral separation.
`timescale 1ns / 1ps

module tb_pid_integral_separation;
   import pis_pkg::*;

   localparam int     PeriodNs    = 4;
   localparam int     ResetCycles = 11;
   localparam int     MaxReported = 10;
   localparam int     DrainCycles = 8;
   localparam longint TimeoutNs   = 2000000;
   localparam longint DriveMax    = (longint'(1) <<< 31) - 1;
   localparam longint DriveMin    = -(longint'(1) <<< 31);

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // tdata: target_value[15:0], measured_value[31:16], armed[32], throttle[43:33], pad[47:44]
   logic [ReqDataWidth-1:0]  req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // tdata: drive_value[31:0]
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index  = '0;
   logic [CsrDataWidth-1:0]  csr_wdata  = '0;

   pid_integral_separation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Controller settings as the block should hold them
   cfg_type model_cfg = '{kp_gain: '0, ki_gain: '0, kd_gain: '0,
                          separation_limit: SEPARATION_LIMIT_RESET,
                          integral_clamp: INTEGRAL_CLAMP_RESET,
                          throttle_threshold: THROTTLE_THRESHOLD_RESET};

   // Controller state as the block should hold it
   logic signed [ErrorWidth-1:0]    last_error   = '0;
   logic signed [IntegralWidth-1:0] integral_acc = '0;
   logic                            integrating  = 1'b0;

   req_fields_type          pending_samples[$];
   logic [DriveWidth-1:0]   expected_drive[$];
   req_fields_type          in_flight;
   int                      burst_left = 0;
   int                      gap_left   = 0;
   int                      ready_count = 0;
   int                      ready_mode  = 0;
   int                      mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #(PeriodNs / 2) clock = ~clock;
   end

   initial begin
      #(TimeoutNs);
      $display("Simulation FAILED");
      $finish;
   end

   // Form the drive output for one sample, then advance the controller state
   function automatic logic [DriveWidth-1:0] compute_drive(req_fields_type s);
      longint err, diff, total, drive, meas, lim, clamp, acc;
      err   = longint'($signed(s.target_value)) - longint'($signed(s.measured_value));
      diff  = err - longint'(last_error);
      total = longint'(model_cfg.kp_gain) * err + longint'(model_cfg.kd_gain) * diff;
      if (integrating) begin
         total += longint'(model_cfg.ki_gain) * longint'(integral_acc);
      end
      drive = total >>> 8;
      if (drive > DriveMax) begin
         drive = DriveMax;
      end
      if (drive < DriveMin) begin
         drive = DriveMin;
      end
      meas = longint'($signed(s.measured_value));
      if (s.armed && s.throttle >= model_cfg.throttle_threshold) begin
         lim = longint'(model_cfg.separation_limit);
         if (meas > lim || meas < -lim) begin
            integrating = 1'b0;
         end else begin
            clamp = longint'(model_cfg.integral_clamp);
            acc   = longint'(integral_acc) + err;
            if (acc > clamp) begin
               acc = clamp;
            end
            if (acc < -clamp) begin
               acc = -clamp;
            end
            integral_acc = acc[IntegralWidth-1:0];
            integrating  = 1'b1;
         end
      end else begin
         integral_acc = '0;
      end
      last_error = err[ErrorWidth-1:0];
      return drive[DriveWidth-1:0];
   endfunction

   function automatic void add_sample(int target, int measure, bit armed, int throttle);
      req_fields_type s;
      s.target_value   = ValueWidth'(target);
      s.measured_value = ValueWidth'(measure);
      s.armed          = armed;
      s.throttle       = ThrottleWidth'(throttle);
      pending_samples.push_back(s);
   endfunction

   function automatic int clip_value(int v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // Mostly samples that integrate, some at the separation and throttle edges, rest noise
   function automatic req_fields_type random_sample();
      req_fields_type s;
      int pick, lim, thr, meas, targ;
      pick = $urandom_range(0, 99);
      lim  = int'(model_cfg.separation_limit);
      thr  = int'(model_cfg.throttle_threshold);
      s.target_value   = ValueWidth'($urandom());
      s.measured_value = ValueWidth'($urandom());
      s.armed          = 1'($urandom());
      s.throttle       = ThrottleWidth'($urandom());
      if (pick < 60) begin
         meas = int'($urandom_range(0, 2 * lim)) - lim;
         if ($urandom_range(0, 1) == 0) begin
            targ = clip_value(meas + int'($urandom_range(0, 400)) - 200);
         end else begin
            targ = int'($urandom_range(0, 65535)) - 32768;
         end
         s.target_value   = ValueWidth'(targ);
         s.measured_value = ValueWidth'(meas);
         s.armed          = 1'b1;
         s.throttle       = ThrottleWidth'($urandom_range(2047, thr));
      end else if (pick < 72) begin
         meas = clip_value(int'($urandom_range(0, 1)) + lim);
         if ($urandom_range(0, 1) == 0) begin
            meas = clip_value(-meas);
         end
         s.measured_value = ValueWidth'(meas);
         s.armed          = 1'b1;
         if (thr > 0 && $urandom_range(0, 3) == 0) begin
            s.throttle = ThrottleWidth'(thr - 1);
         end else begin
            s.throttle = ThrottleWidth'(thr);
         end
      end
      return s;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.kp_gain            = GainWidth'($urandom());
      c.ki_gain            = GainWidth'($urandom());
      c.kd_gain            = GainWidth'($urandom());
      c.separation_limit   = LimitWidth'($urandom());
      c.integral_clamp     = ClampWidth'($urandom_range(0, 200000));
      c.throttle_threshold = ThrottleWidth'($urandom_range(0, 1200));
      // Push one field to an extreme in every setting
      case ($urandom_range(0, 5))
         0: c.kp_gain = '1;
         1: c.ki_gain = '1;
         2: c.kd_gain = '0;
         3: c.integral_clamp = '1;
         4: c.separation_limit = '1;
         default: c.throttle_threshold = '0;
      endcase
      return c;
   endfunction

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_KP_GAIN:            model_cfg.kp_gain            = value[GainWidth-1:0];
         CSR_KI_GAIN:            model_cfg.ki_gain            = value[GainWidth-1:0];
         CSR_KD_GAIN:            model_cfg.kd_gain            = value[GainWidth-1:0];
         CSR_SEPARATION_LIMIT:   model_cfg.separation_limit   = value[LimitWidth-1:0];
         CSR_INTEGRAL_CLAMP:     model_cfg.integral_clamp     = value[ClampWidth-1:0];
         CSR_THROTTLE_THRESHOLD: model_cfg.throttle_threshold = value[ThrottleWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input cfg_type c);
      write_register(CSR_KP_GAIN, CsrDataWidth'(c.kp_gain));
      write_register(CSR_KI_GAIN, CsrDataWidth'(c.ki_gain));
      write_register(CSR_KD_GAIN, CsrDataWidth'(c.kd_gain));
      write_register(CSR_SEPARATION_LIMIT, CsrDataWidth'(c.separation_limit));
      write_register(CSR_INTEGRAL_CLAMP, CsrDataWidth'(c.integral_clamp));
      write_register(CSR_THROTTLE_THRESHOLD, CsrDataWidth'(c.throttle_threshold));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold the sender until every sample is taken and every drive value is back
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_tvalid || expected_drive.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic flag_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= MaxReported) begin
         $display("mismatch at %0t: %s", $realtime, detail);
      end
   endtask

   // Sample driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_drive.push_back(compute_drive(in_flight));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               in_flight = pending_samples.pop_front();
               req_tdata  <= ReqDataWidth'(in_flight);
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transaction, stall on a shifting pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drive.size() == 0) begin
               flag_mismatch($sformatf("drive_value 0x%08h arrived with none pending",
                                       rsp_tdata));
            end else if (rsp_tdata !== expected_drive[0]) begin
               flag_mismatch($sformatf("drive_value expected %0d (0x%08h), got %0d (0x%08h)",
                                       $signed(expected_drive[0]), expected_drive[0],
                                       $signed(rsp_tdata), rsp_tdata));
               void'(expected_drive.pop_front());
            end else begin
               void'(expected_drive.pop_front());
            end
         end
         ready_count++;
         if (ready_count % 96 == 0) begin
            ready_mode = $urandom_range(0, 3);
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= (ready_count % 3 == 0);
            2: rsp_tready <= 1'($urandom());
            default: rsp_tready <= (ready_count % 16) < 11;
         endcase
      end
   end

   initial begin
      cfg_type c;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero gains, state still moves
      add_sample(1000, 0, 1'b1, 180);
      add_sample(-500, 3999, 1'b1, 2047);
      add_sample(0, 0, 1'b0, 0);
      add_sample(32767, -32768, 1'b1, 179);
      wait_idle();

      // Directed: field extremes, separation and throttle edges, rounding
      c = '{kp_gain: 16'd256, ki_gain: 16'd128, kd_gain: 16'd512,
            separation_limit: 15'd4000, integral_clamp: 23'd32000,
            throttle_threshold: 11'd180};
      load_settings(c);
      add_sample(32767, -32768, 1'b1, 2047);
      add_sample(-32768, 32767, 1'b1, 2047);
      add_sample(100, 4000, 1'b1, 180);
      add_sample(100, -4000, 1'b1, 180);
      add_sample(0, 4001, 1'b1, 2047);
      add_sample(50, -4001, 1'b1, 500);
      add_sample(200, 0, 1'b1, 179);
      add_sample(200, 0, 1'b0, 2047);
      add_sample(0, 1, 1'b1, 200);
      add_sample(0, 0, 1'b1, 0);
      add_sample(-1, 0, 1'b1, 1000);
      add_sample(3, 0, 1'b1, 1024);
      wait_idle();

      // Zero clamp pins the integral; unit kp shows floor rounding
      c = '{kp_gain: 16'd1, ki_gain: '1, kd_gain: '0,
            separation_limit: 15'd4000, integral_clamp: '0,
            throttle_threshold: 11'd180};
      load_settings(c);
      add_sample(1000, 0, 1'b1, 2047);
      add_sample(1000, 0, 1'b1, 2047);
      add_sample(-1, 0, 1'b1, 2047);
      add_sample(-1000, 0, 1'b1, 2047);
      wait_idle();

      // Max gains and clamp: drive the integral into both saturation rails
      c = '{kp_gain: '1, ki_gain: '1, kd_gain: '1, separation_limit: '1,
            integral_clamp: '1, throttle_threshold: '0};
      load_settings(c);
      repeat (140) add_sample(32767, -32767, 1'b1, int'($urandom_range(0, 2047)));
      add_sample(0, 0, 1'b0, 0);
      repeat (140) add_sample(-32768, 32767, 1'b1, int'($urandom_range(0, 2047)));
      wait_idle();

      // Zero clamp with random gains
      c = random_settings();
      c.integral_clamp = '0;
      load_settings(c);
      repeat (100) pending_samples.push_back(random_sample());
      wait_idle();

      // Zero gains, zero limit, highest threshold
      c = '{kp_gain: '0, ki_gain: '0, kd_gain: '0, separation_limit: '0,
            integral_clamp: 23'd5, throttle_threshold: '1};
      load_settings(c);
      repeat (80) pending_samples.push_back(random_sample());
      wait_idle();

      // Random settings, one batch each
      repeat (6) begin
         load_settings(random_settings());
         repeat (115) pending_samples.push_back(random_sample());
         wait_idle();
      end

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_drive.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/pis_pkg.sv
rtl/pis_csr.sv
rtl/pis_core.sv
rtl/pis_output.sv
rtl/pid_integral_separation.sv
rtl/pis_checker.sv
test/tb_pid_integral_separation.sv
